### rtl/cbts_pkg.sv
`default_nettype none

package cbts_pkg;

    localparam int MAX_QUANTA = 25;
    localparam int MIN_QUANTA = 4;
    localparam int QUANTA_W   = $clog2(MAX_QUANTA + 1);
    localparam int DIV_W      = 32;
    localparam int STEP_W     = $clog2(DIV_W);
    localparam int PRESC_W    = 30;
    localparam int SEG1_W     = 4;
    localparam int SEG2_W     = 3;
    localparam int SJW_W      = 2;

    localparam logic [QUANTA_W-1:0] SYNC_AND_FIXED = QUANTA_W'(3);
    localparam logic [SJW_W-1:0]    JUMP_WIDTH_FIXED = SJW_W'(2);

    typedef struct packed {
        logic [31:0] clock_hz;
        logic [31:0] bit_rate;
    } in_beat_t;

    typedef struct packed {
        logic [PRESC_W-1:0] prescaler_minus_one;
        logic [SEG1_W-1:0]  segment_one;
        logic [SEG2_W-1:0]  segment_two;
        logic [SJW_W-1:0]   jump_width;
        logic               fault;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_TRIAL,
        ST_DONE
    } cbts_state_t;

    // x / 3 for small x: multiply by 171/512, exact for x below 510
    function automatic logic [QUANTA_W-1:0] div3(input logic [QUANTA_W-1:0] x);
        logic [QUANTA_W+8:0] p;
        begin
            p = (QUANTA_W + 9)'(x) * (QUANTA_W + 9)'(171);
            return p[QUANTA_W+8:9];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/can_bit_timing_search.sv
// Flow: a restoring division of clock_hz by bit_rate gives the total prescaler,
// then one division of that total per trial length (up to 22 lengths), then the
// result beat is formed; a zero input goes straight to the result beat.
// All divisions use the shared 32-bit restoring divider (one quotient bit per
// cycle). One item at a time.
// Reset: rst_n is asynchronous, active low; clears sequencer and out_valid.
`default_nettype none

module can_bit_timing_search
    import cbts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_beat_t      out_data
);

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    cbts_state_t state_reg, state_next;

    logic [STEP_W-1:0]   step_reg, step_next;     // divider bit counter
    logic [DIV_W-1:0]    rem_reg, rem_next;       // partial remainder
    logic [DIV_W-1:0]    quo_reg, quo_next;       // dividend in, quotient out
    logic [DIV_W-1:0]    dvsr_reg, dvsr_next;     // divisor

    logic [DIV_W-1:0]    total_reg, total_next;   // total prescaler
    logic [QUANTA_W-1:0] q_reg, q_next;           // length under trial
    logic [QUANTA_W-1:0] best_len_reg, best_len_next;
    logic [QUANTA_W-1:0] best_rem_reg, best_rem_next;
    logic [DIV_W-1:0]    best_quo_reg, best_quo_next;
    logic                fault_reg, fault_next;

    logic                out_valid_reg, out_valid_next;
    out_beat_t           out_reg, out_next;

    // ---------------------------------------------------------------
    // Shared restoring divider step: one quotient bit per cycle
    // ---------------------------------------------------------------
    logic [DIV_W:0]   trial_sub;
    logic [DIV_W:0]   shifted;
    logic             ge;
    logic [DIV_W-1:0] rem_step;
    logic [DIV_W-1:0] quo_step;
    logic             div_last;

    assign shifted   = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_sub = shifted - {1'b0, dvsr_reg};
    assign ge        = ~trial_sub[DIV_W];
    assign rem_step  = ge ? trial_sub[DIV_W-1:0] : shifted[DIV_W-1:0];
    assign quo_step  = {quo_reg[DIV_W-2:0], ge};
    assign div_last  = (step_reg == STEP_W'(DIV_W - 1));

    // Trial outcome, valid when div_last in ST_TRIAL
    logic [QUANTA_W-1:0] trial_rem;
    logic                exact_hit;
    logic                better;

    assign trial_rem = rem_step[QUANTA_W-1:0];   // remainder below q
    assign exact_hit = (trial_rem == '0);
    assign better    = (trial_rem < best_rem_reg);

    logic out_free;
    assign out_free = ~out_valid_reg | ~out_stall;

    // Result fields from the chosen length
    logic [QUANTA_W-1:0] len3;
    logic [QUANTA_W-1:0] seg2_full;
    logic [QUANTA_W-1:0] seg1_full;
    logic                no_quot;

    assign len3      = best_len_reg - SYNC_AND_FIXED;
    assign seg2_full = div3(len3);
    assign seg1_full = len3 - seg2_full;
    assign no_quot   = (best_quo_reg == '0);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.clock_hz == '0 || in_data.bit_rate == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_TOTAL;
                end
            end
            ST_TOTAL:
            begin
                if (div_last)
                    state_next = ST_TRIAL;
            end
            ST_TRIAL:
            begin
                if (div_last && (exact_hit || q_reg == QUANTA_W'(MIN_QUANTA)))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvsr_next      = dvsr_reg;
        total_next     = total_reg;
        q_next         = q_reg;
        best_len_next  = best_len_reg;
        best_rem_next  = best_rem_reg;
        best_quo_next  = best_quo_reg;
        fault_next     = fault_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    step_next     = '0;
                    rem_next      = '0;
                    quo_next      = in_data.clock_hz;
                    dvsr_next     = in_data.bit_rate;
                    best_len_next = QUANTA_W'(MAX_QUANTA);
                    best_rem_next = '1;
                    best_quo_next = '0;
                    fault_next    = (in_data.clock_hz == '0 || in_data.bit_rate == '0);
                end
            end
            ST_TOTAL:
            begin
                step_next = step_reg + 1'b1;
                rem_next  = rem_step;
                quo_next  = quo_step;
                if (div_last)
                begin
                    // start first trial at the longest bit
                    total_next = quo_step;
                    step_next  = '0;
                    rem_next   = '0;
                    quo_next   = quo_step;
                    q_next     = QUANTA_W'(MAX_QUANTA);
                    dvsr_next  = DIV_W'(MAX_QUANTA);
                end
            end
            ST_TRIAL:
            begin
                step_next = step_reg + 1'b1;
                rem_next  = rem_step;
                quo_next  = quo_step;
                if (div_last)
                begin
                    if (exact_hit || better)
                    begin
                        best_len_next = q_reg;
                        best_rem_next = trial_rem;
                        best_quo_next = quo_step;
                    end
                    q_next    = q_reg - 1'b1;
                    dvsr_next = DIV_W'(q_reg - 1'b1);
                    step_next = '0;
                    rem_next  = '0;
                    quo_next  = total_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.jump_width  = JUMP_WIDTH_FIXED;
                    if (fault_reg || no_quot)
                    begin
                        out_next.prescaler_minus_one = '0;
                        out_next.segment_one         = '0;
                        out_next.segment_two         = '0;
                        out_next.fault               = 1'b1;
                    end
                    else
                    begin
                        out_next.prescaler_minus_one = PRESC_W'(best_quo_reg - 1'b1);
                        out_next.segment_one         = seg1_full[SEG1_W-1:0];
                        out_next.segment_two         = seg2_full[SEG2_W-1:0];
                        out_next.fault               = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvsr_reg     <= dvsr_next;
        total_reg    <= total_next;
        q_reg        <= q_next;
        best_len_reg <= best_len_next;
        best_rem_reg <= best_rem_next;
        best_quo_reg <= best_quo_next;
        fault_reg    <= fault_next;
        out_reg      <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
